FILE: rtl/cpu65_pkg.sv
// ----------------------------------------------------------------------------
// cpu65_pkg
// Shared types and codes for the 6502 data-operation execute unit.
// ----------------------------------------------------------------------------
package cpu65_pkg;

    // Operation codes carried by the kind field
    localparam logic [5:0] OP_ADC = 6'd0;
    localparam logic [5:0] OP_SBC = 6'd1;
    localparam logic [5:0] OP_BIT = 6'd2;
    localparam logic [5:0] OP_AND = 6'd3;
    localparam logic [5:0] OP_EOR = 6'd4;
    localparam logic [5:0] OP_ORA = 6'd5;
    localparam logic [5:0] OP_ASL = 6'd6;
    localparam logic [5:0] OP_LSR = 6'd7;
    localparam logic [5:0] OP_ROL = 6'd8;
    localparam logic [5:0] OP_ROR = 6'd9;
    localparam logic [5:0] OP_DEC = 6'd10;
    localparam logic [5:0] OP_DEX = 6'd11;
    localparam logic [5:0] OP_DEY = 6'd12;
    localparam logic [5:0] OP_INC = 6'd13;
    localparam logic [5:0] OP_INX = 6'd14;
    localparam logic [5:0] OP_INY = 6'd15;
    localparam logic [5:0] OP_PHP = 6'd16;
    localparam logic [5:0] OP_PHA = 6'd17;
    localparam logic [5:0] OP_PLP = 6'd18;
    localparam logic [5:0] OP_PLA = 6'd19;
    localparam logic [5:0] OP_SEI = 6'd20;
    localparam logic [5:0] OP_SED = 6'd21;
    localparam logic [5:0] OP_SEC = 6'd22;
    localparam logic [5:0] OP_CLD = 6'd23;
    localparam logic [5:0] OP_CLI = 6'd24;
    localparam logic [5:0] OP_CLC = 6'd25;
    localparam logic [5:0] OP_CLV = 6'd26;
    localparam logic [5:0] OP_LDA = 6'd27;
    localparam logic [5:0] OP_LDX = 6'd28;
    localparam logic [5:0] OP_LDY = 6'd29;
    localparam logic [5:0] OP_STA = 6'd30;
    localparam logic [5:0] OP_STX = 6'd31;
    localparam logic [5:0] OP_STY = 6'd32;
    localparam logic [5:0] OP_TAX = 6'd33;
    localparam logic [5:0] OP_TAY = 6'd34;
    localparam logic [5:0] OP_TSX = 6'd35;
    localparam logic [5:0] OP_TXA = 6'd36;
    localparam logic [5:0] OP_TXS = 6'd37;
    localparam logic [5:0] OP_TYA = 6'd38;
    localparam logic [5:0] OP_CMP = 6'd39;
    localparam logic [5:0] OP_CPX = 6'd40;
    localparam logic [5:0] OP_CPY = 6'd41;
    localparam logic [5:0] OP_NOP = 6'd42;

    // Stack access codes
    localparam logic [1:0] SA_NONE = 2'd0;
    localparam logic [1:0] SA_PUSH = 2'd1;
    localparam logic [1:0] SA_POP  = 2'd2;

    // Bit positions in the internal 7-bit flag word (N V B D I Z C)
    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_I = 2;
    localparam int FL_D = 3;
    localparam int FL_B = 4;
    localparam int FL_V = 5;
    localparam int FL_N = 6;

    localparam logic [7:0] SP_RESET = 8'hFF;

    // Architectural register file
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [6:0] fl;
    } t_regs;

    // Per-item side effects besides the register values
    typedef struct packed {
        logic       we;
        logic [7:0] wd;
        logic [1:0] sa;
        logic [8:0] saddr;
        logic       ni;
    } t_effect;

    // Packed status byte: N V 0 B D I Z C
    function automatic logic [7:0] pack_status(input logic [6:0] fl);
        return {fl[FL_N], fl[FL_V], 1'b0, fl[4:0]};
    endfunction

endpackage

FILE: rtl/cpu65_alu.sv
// ----------------------------------------------------------------------------
// cpu65_alu
// Combinational execute logic: one decoded operation against the current
// registers gives the next registers and the memory / stack side effects.
// ----------------------------------------------------------------------------
module cpu65_alu
    import cpu65_pkg::*;
(
    input  logic [5:0] i_kind,
    input  logic [7:0] i_operand,
    input  logic       i_acc_mode,
    input  t_regs      i_regs,
    output t_regs      o_regs,
    output t_effect    o_eff
);

    logic [7:0] a;
    logic [7:0] m;
    logic       c;
    logic [8:0] sum9;
    logic [8:0] diff9;
    logic [8:0] cmp_a;
    logic [8:0] cmp_x;
    logic [8:0] cmp_y;
    logic [7:0] sh_src;
    logic [7:0] sh_res;
    logic       sh_c;
    logic [7:0] sp_dec;
    logic [7:0] sp_inc;
    logic [7:0] m_dec;
    logic [7:0] m_inc;
    logic [7:0] x_dec;
    logic [7:0] x_inc;
    logic [7:0] y_dec;
    logic [7:0] y_inc;

    assign a = i_regs.a;
    assign m = i_operand;
    assign c = i_regs.fl[FL_C];

    // Adders and incrementers
    assign sum9  = {1'b0, a} + {1'b0, m} + {8'd0, c};
    assign diff9 = {1'b0, a} - {1'b0, m} - {8'd0, ~c};
    assign cmp_a = {1'b0, a} - {1'b0, m};
    assign cmp_x = {1'b0, i_regs.x} - {1'b0, m};
    assign cmp_y = {1'b0, i_regs.y} - {1'b0, m};
    assign sp_dec = i_regs.sp - 8'd1;
    assign sp_inc = i_regs.sp + 8'd1;
    assign m_dec  = m - 8'd1;
    assign m_inc  = m + 8'd1;
    assign x_dec  = i_regs.x - 8'd1;
    assign x_inc  = i_regs.x + 8'd1;
    assign y_dec  = i_regs.y - 8'd1;
    assign y_inc  = i_regs.y + 8'd1;

    // Shifter: source is A or the operand byte
    assign sh_src = i_acc_mode ? a : m;
    always_comb begin
        case (i_kind)
            OP_ASL: begin
                sh_res = {sh_src[6:0], 1'b0};
                sh_c   = sh_src[7];
            end
            OP_LSR: begin
                sh_res = {1'b0, sh_src[7:1]};
                sh_c   = sh_src[0];
            end
            OP_ROL: begin
                sh_res = {sh_src[6:0], c};
                sh_c   = sh_src[7];
            end
            default: begin
                sh_res = {c, sh_src[7:1]};
                sh_c   = sh_src[0];
            end
        endcase
    end

    // Operation decode
    always_comb begin
        o_regs = i_regs;
        o_eff  = '0;
        unique case (i_kind) inside
            OP_ADC: begin
                o_regs.a        = sum9[7:0];
                o_regs.fl[FL_N] = sum9[7];
                o_regs.fl[FL_Z] = (sum9[7:0] == 8'd0);
                o_regs.fl[FL_V] = ~(a[7] ^ m[7]) & (a[7] ^ sum9[7]);
                o_regs.fl[FL_C] = sum9[8];
            end
            OP_SBC: begin
                o_regs.a        = diff9[7:0];
                o_regs.fl[FL_N] = diff9[7];
                o_regs.fl[FL_Z] = (diff9[7:0] == 8'd0);
                o_regs.fl[FL_V] = (a[7] ^ diff9[7]) & (a[7] ^ m[7]);
                o_regs.fl[FL_C] = ~diff9[8];
            end
            OP_BIT: begin
                o_regs.fl[FL_N] = m[7];
                o_regs.fl[FL_V] = m[6];
                o_regs.fl[FL_Z] = ((a & m) == 8'd0);
            end
            OP_AND: begin
                o_regs.a        = a & m;
                o_regs.fl[FL_N] = a[7] & m[7];
                o_regs.fl[FL_Z] = ((a & m) == 8'd0);
            end
            OP_EOR: begin
                o_regs.a        = a ^ m;
                o_regs.fl[FL_N] = a[7] ^ m[7];
                o_regs.fl[FL_Z] = ((a ^ m) == 8'd0);
            end
            OP_ORA: begin
                o_regs.a        = a | m;
                o_regs.fl[FL_N] = a[7] | m[7];
                o_regs.fl[FL_Z] = ((a | m) == 8'd0);
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                o_regs.fl[FL_C] = sh_c;
                o_regs.fl[FL_N] = sh_res[7];
                o_regs.fl[FL_Z] = (sh_res == 8'd0);
                if (i_acc_mode) begin
                    o_regs.a = sh_res;
                end else begin
                    o_eff.we = 1'b1;
                    o_eff.wd = sh_res;
                end
            end
            OP_DEC: begin
                o_regs.fl[FL_N] = m_dec[7];
                o_regs.fl[FL_Z] = (m_dec == 8'd0);
                o_eff.we        = 1'b1;
                o_eff.wd        = m_dec;
            end
            OP_INC: begin
                o_regs.fl[FL_N] = m_inc[7];
                o_regs.fl[FL_Z] = (m_inc == 8'd0);
                o_eff.we        = 1'b1;
                o_eff.wd        = m_inc;
            end
            OP_DEX: begin
                o_regs.x        = x_dec;
                o_regs.fl[FL_N] = x_dec[7];
                o_regs.fl[FL_Z] = (x_dec == 8'd0);
            end
            OP_INX: begin
                o_regs.x        = x_inc;
                o_regs.fl[FL_N] = x_inc[7];
                o_regs.fl[FL_Z] = (x_inc == 8'd0);
            end
            OP_DEY: begin
                o_regs.y        = y_dec;
                o_regs.fl[FL_N] = y_dec[7];
                o_regs.fl[FL_Z] = (y_dec == 8'd0);
            end
            OP_INY: begin
                o_regs.y        = y_inc;
                o_regs.fl[FL_N] = y_inc[7];
                o_regs.fl[FL_Z] = (y_inc == 8'd0);
            end
            // Push: address uses SP before the decrement
            OP_PHP, OP_PHA: begin
                o_eff.wd    = (i_kind == OP_PHP) ? (pack_status(i_regs.fl) | 8'h30) : a;
                o_eff.sa    = SA_PUSH;
                o_eff.saddr = {1'b1, i_regs.sp};
                o_regs.sp   = sp_dec;
            end
            // Pop: address uses SP after the increment
            OP_PLP, OP_PLA: begin
                o_regs.sp   = sp_inc;
                o_eff.sa    = SA_POP;
                o_eff.saddr = {1'b1, sp_inc};
                if (i_kind == OP_PLP) begin
                    o_regs.fl = {m[7], m[6], m[4:0]};
                end else begin
                    o_regs.a = m;
                end
            end
            OP_SEI: o_regs.fl[FL_I] = 1'b1;
            OP_SED: o_regs.fl[FL_D] = 1'b1;
            OP_SEC: o_regs.fl[FL_C] = 1'b1;
            OP_CLD: o_regs.fl[FL_D] = 1'b0;
            OP_CLI: o_regs.fl[FL_I] = 1'b0;
            OP_CLC: o_regs.fl[FL_C] = 1'b0;
            OP_CLV: o_regs.fl[FL_V] = 1'b0;
            OP_LDA: begin
                o_regs.a        = m;
                o_regs.fl[FL_N] = m[7];
                o_regs.fl[FL_Z] = (m == 8'd0);
            end
            OP_LDX: begin
                o_regs.x        = m;
                o_regs.fl[FL_N] = m[7];
                o_regs.fl[FL_Z] = (m == 8'd0);
            end
            OP_LDY: begin
                o_regs.y        = m;
                o_regs.fl[FL_N] = m[7];
                o_regs.fl[FL_Z] = (m == 8'd0);
            end
            OP_STA: begin
                o_eff.we = 1'b1;
                o_eff.wd = a;
            end
            OP_STX: begin
                o_eff.we = 1'b1;
                o_eff.wd = i_regs.x;
            end
            OP_STY: begin
                o_eff.we = 1'b1;
                o_eff.wd = i_regs.y;
            end
            OP_TAX: begin
                o_regs.x        = a;
                o_regs.fl[FL_N] = a[7];
                o_regs.fl[FL_Z] = (a == 8'd0);
            end
            OP_TAY: begin
                o_regs.y        = a;
                o_regs.fl[FL_N] = a[7];
                o_regs.fl[FL_Z] = (a == 8'd0);
            end
            OP_TSX: begin
                o_regs.x        = i_regs.sp;
                o_regs.fl[FL_N] = i_regs.sp[7];
                o_regs.fl[FL_Z] = (i_regs.sp == 8'd0);
            end
            OP_TXA: begin
                o_regs.a        = i_regs.x;
                o_regs.fl[FL_N] = i_regs.x[7];
                o_regs.fl[FL_Z] = (i_regs.x == 8'd0);
            end
            OP_TXS: o_regs.sp = i_regs.x;
            OP_TYA: begin
                o_regs.a        = i_regs.y;
                o_regs.fl[FL_N] = i_regs.y[7];
                o_regs.fl[FL_Z] = (i_regs.y == 8'd0);
            end
            // Compares: carry is the inverted borrow
            OP_CMP: begin
                o_regs.fl[FL_N] = cmp_a[7];
                o_regs.fl[FL_Z] = (cmp_a[7:0] == 8'd0);
                o_regs.fl[FL_C] = ~cmp_a[8];
            end
            OP_CPX: begin
                o_regs.fl[FL_N] = cmp_x[7];
                o_regs.fl[FL_Z] = (cmp_x[7:0] == 8'd0);
                o_regs.fl[FL_C] = ~cmp_x[8];
            end
            OP_CPY: begin
                o_regs.fl[FL_N] = cmp_y[7];
                o_regs.fl[FL_Z] = (cmp_y[7:0] == 8'd0);
                o_regs.fl[FL_C] = ~cmp_y[8];
            end
            OP_NOP: ;
            default: o_eff.ni = 1'b1;
        endcase
    end

endmodule

FILE: rtl/cpu6502_execute_unit.sv
// ----------------------------------------------------------------------------
// cpu6502_execute_unit
// Data-operation execute stage of a 6502-style core: holds A, X, Y, SP and
// the flags, executes one decoded operation per item.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake              | Payload
//   in      | into unit | i_in_valid/o_in_stall  | kind, operand, acc_mode
//   out     | out of    | o_out_valid/i_out_stall| write, stack, regs, status
//
// Throughput is one item per cycle unless the output stalls; an item passes the
// input register, then executes into the result register and the architectural
// registers. The register feedback through the 8-bit ALU sets the cycle.
// Synchronous active-low reset: A, X, Y and flags clear, SP goes to 0xFF.
// A stall on the output holds the result and, once the input register is
// full, stalls the input.
// ----------------------------------------------------------------------------
module cpu6502_execute_unit
    import cpu65_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [5:0] i_kind,
    input  logic [7:0] i_operand,
    input  logic       i_acc_mode,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_write_enable,
    output logic [7:0] o_write_data,
    output logic [1:0] o_stack_access,
    output logic [8:0] o_stack_address,
    output logic [7:0] o_acc_out,
    output logic [7:0] o_x_out,
    output logic [7:0] o_y_out,
    output logic [7:0] o_sp_out,
    output logic [7:0] o_status_out,
    output logic       o_not_implemented
);

    // Input register
    logic       r_s1_valid;
    logic [5:0] r_s1_kind;
    logic [7:0] r_s1_operand;
    logic       r_s1_acc_mode;

    // Architectural state and result register
    t_regs      r_regs;
    t_regs      n_regs;
    t_effect    n_eff;
    t_effect    r_eff;
    logic       r_out_valid;

    logic       s1_adv;
    logic       s1_exec;

    assign s1_adv     = ~r_out_valid | ~i_out_stall;
    assign s1_exec    = r_s1_valid & s1_adv;
    assign o_in_stall = r_s1_valid & ~s1_adv;

    // Input capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_kind     <= i_kind;
            r_s1_operand  <= i_operand;
            r_s1_acc_mode <= i_acc_mode;
        end
    end

    cpu65_alu u_alu (
        .i_kind     (r_s1_kind),
        .i_operand  (r_s1_operand),
        .i_acc_mode (r_s1_acc_mode),
        .i_regs     (r_regs),
        .o_regs     (n_regs),
        .o_eff      (n_eff)
    );

    // Architectural registers update as the item executes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.a  <= 8'd0;
            r_regs.x  <= 8'd0;
            r_regs.y  <= 8'd0;
            r_regs.sp <= SP_RESET;
            r_regs.fl <= 7'd0;
        end else if (s1_exec) begin
            r_regs <= n_regs;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_exec) begin
            r_eff <= n_eff;
        end
    end

    // Register outputs track the state left by the last executed item
    assign o_out_valid       = r_out_valid;
    assign o_write_enable    = r_eff.we;
    assign o_write_data      = r_eff.wd;
    assign o_stack_access    = r_eff.sa;
    assign o_stack_address   = r_eff.saddr;
    assign o_not_implemented = r_eff.ni;
    assign o_acc_out         = r_regs.a;
    assign o_x_out           = r_regs.x;
    assign o_y_out           = r_regs.y;
    assign o_sp_out          = r_regs.sp;
    assign o_status_out      = pack_status(r_regs.fl);

endmodule

FILE: rtl/cpu65_checker.sv
// ----------------------------------------------------------------------------
// cpu65_checker
// Port-level checks for the execute unit, attached by bind.
// ----------------------------------------------------------------------------
module cpu65_checker
    import cpu65_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_write_enable,
    input logic [7:0] o_write_data,
    input logic [1:0] o_stack_access,
    input logic [8:0] o_stack_address,
    input logic [7:0] o_sp_out,
    input logic [7:0] o_status_out,
    input logic       o_not_implemented
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_write_data)
            && $stable(o_stack_address) && $stable(o_status_out))
        else $error("stalled result changed");

    // Unknown operation has no side effects
    a_ni_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_not_implemented |->
            !o_write_enable && o_stack_access == SA_NONE && o_stack_address == 9'd0)
        else $error("unknown operation with side effect");

    // Push address is the stack pointer before the decrement
    a_push_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stack_access == SA_PUSH |->
            o_stack_address[8] && o_stack_address[7:0] == o_sp_out + 8'd1)
        else $error("push address does not match stack pointer");

    // Pop address is the stack pointer after the increment
    a_pop_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stack_access == SA_POP |->
            o_stack_address[8] && o_stack_address[7:0] == o_sp_out && !o_write_enable)
        else $error("pop address does not match stack pointer");

endmodule

bind cpu6502_execute_unit cpu65_checker u_cpu65_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_write_enable    (o_write_enable),
    .o_write_data      (o_write_data),
    .o_stack_access    (o_stack_access),
    .o_stack_address   (o_stack_address),
    .o_sp_out          (o_sp_out),
    .o_status_out      (o_status_out),
    .o_not_implemented (o_not_implemented)
);

FILE: bench/cpu6502_execute_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu6502_execute_unit_checker
// Watches both channels of the execute unit. Every accepted item runs through
// a register-level model of the 6502 data operations, and every accepted
// result is compared field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module cpu6502_execute_unit_checker
    import cpu65_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [5:0] i_kind,
    input  logic [7:0] i_operand,
    input  logic       i_acc_mode,
    // result channel
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_write_enable,
    input  logic [7:0] i_write_data,
    input  logic [1:0] i_stack_access,
    input  logic [8:0] i_stack_address,
    input  logic [7:0] i_acc_out,
    input  logic [7:0] i_x_out,
    input  logic [7:0] i_y_out,
    input  logic [7:0] i_sp_out,
    input  logic [7:0] i_status_out,
    input  logic       i_not_implemented,
    // bookkeeping for the test top
    output int         o_fail_count,
    output int         o_outstanding,
    output int         o_items_seen,
    output int         o_results_seen
);

    typedef struct packed {
        logic       we;
        logic [7:0] wd;
        logic [1:0] sa;
        logic [8:0] saddr;
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] status;
        logic       ni;
    } t_exec_result;

    // Model copy of the architectural registers
    logic [7:0] reg_a;
    logic [7:0] reg_x;
    logic [7:0] reg_y;
    logic [7:0] reg_sp;
    logic [6:0] flags;

    t_exec_result expected_results[$];
    int fail_count   = 0;
    int items_seen   = 0;
    int results_seen = 0;

    assign o_fail_count   = fail_count;
    assign o_items_seen   = items_seen;
    assign o_results_seen = results_seen;
    initial o_outstanding = 0;

    // One line per mismatch, and the count
    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // N V 0 B D I Z C
    function automatic logic [7:0] status_byte(input logic [6:0] f);
        return {f[FL_N], f[FL_V], 1'b0, f[FL_B], f[FL_D], f[FL_I], f[FL_Z], f[FL_C]};
    endfunction

    task automatic set_nz(input logic [7:0] v);
        flags[FL_N] = v[7];
        flags[FL_Z] = (v == 8'h00);
    endtask

    task automatic compare_reg(input logic [7:0] r, input logic [7:0] m);
        logic [8:0] diff;
        diff = {1'b0, r} - {1'b0, m};
        set_nz(diff[7:0]);
        flags[FL_C] = (r >= m);
    endtask

    // Executes one item on the model registers and returns its result
    task automatic execute_op(input logic [5:0] op, input logic [7:0] m,
                              input logic accm, output t_exec_result res);
        logic [8:0] sum;
        logic [7:0] src;
        logic [7:0] r;
        logic [7:0] a_old;
        logic       cin;
        res   = '0;
        a_old = reg_a;
        cin   = flags[FL_C];
        case (op) inside
            OP_ADC: begin
                sum = {1'b0, a_old} + {1'b0, m} + {8'd0, cin};
                set_nz(sum[7:0]);
                flags[FL_V] = ~(a_old[7] ^ m[7]) & (a_old[7] ^ sum[7]);
                flags[FL_C] = sum[8];
                reg_a = sum[7:0];
            end
            OP_SBC: begin
                sum = {1'b0, a_old} - {1'b0, m} - {8'd0, ~cin};
                set_nz(sum[7:0]);
                flags[FL_V] = (a_old[7] ^ sum[7]) & (a_old[7] ^ m[7]);
                flags[FL_C] = ({1'b0, a_old} >= ({1'b0, m} + {8'd0, ~cin}));
                reg_a = sum[7:0];
            end
            OP_BIT: begin
                flags[FL_N] = m[7];
                flags[FL_V] = m[6];
                flags[FL_Z] = ((m & a_old) == 8'h00);
            end
            OP_AND: begin reg_a = a_old & m; set_nz(reg_a); end
            OP_EOR: begin reg_a = a_old ^ m; set_nz(reg_a); end
            OP_ORA: begin reg_a = a_old | m; set_nz(reg_a); end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                src = accm ? a_old : m;
                if (op == OP_ASL) begin
                    flags[FL_C] = src[7];
                    r = {src[6:0], 1'b0};
                end else if (op == OP_LSR) begin
                    flags[FL_C] = src[0];
                    r = {1'b0, src[7:1]};
                end else if (op == OP_ROL) begin
                    flags[FL_C] = src[7];
                    r = {src[6:0], cin};
                end else begin
                    flags[FL_C] = src[0];
                    r = {cin, src[7:1]};
                end
                set_nz(r);
                if (accm) begin
                    reg_a = r;
                end else begin
                    res.we = 1'b1;
                    res.wd = r;
                end
            end
            OP_DEC: begin r = m - 8'd1; set_nz(r); res.we = 1'b1; res.wd = r; end
            OP_INC: begin r = m + 8'd1; set_nz(r); res.we = 1'b1; res.wd = r; end
            OP_DEX: begin reg_x = reg_x - 8'd1; set_nz(reg_x); end
            OP_DEY: begin reg_y = reg_y - 8'd1; set_nz(reg_y); end
            OP_INX: begin reg_x = reg_x + 8'd1; set_nz(reg_x); end
            OP_INY: begin reg_y = reg_y + 8'd1; set_nz(reg_y); end
            // Push uses SP before the decrement
            OP_PHP, OP_PHA: begin
                res.wd    = (op == OP_PHP) ? (status_byte(flags) | 8'h30) : a_old;
                res.sa    = SA_PUSH;
                res.saddr = {1'b1, reg_sp};
                reg_sp    = reg_sp - 8'd1;
            end
            // Pop uses SP after the increment
            OP_PLP, OP_PLA: begin
                reg_sp    = reg_sp + 8'd1;
                res.sa    = SA_POP;
                res.saddr = {1'b1, reg_sp};
                if (op == OP_PLP) begin
                    flags = {m[7], m[6], m[4:0]};
                end else begin
                    reg_a = m;
                end
            end
            OP_SEI: flags[FL_I] = 1'b1;
            OP_SED: flags[FL_D] = 1'b1;
            OP_SEC: flags[FL_C] = 1'b1;
            OP_CLD: flags[FL_D] = 1'b0;
            OP_CLI: flags[FL_I] = 1'b0;
            OP_CLC: flags[FL_C] = 1'b0;
            OP_CLV: flags[FL_V] = 1'b0;
            OP_LDA: begin reg_a = m; set_nz(m); end
            OP_LDX: begin reg_x = m; set_nz(m); end
            OP_LDY: begin reg_y = m; set_nz(m); end
            OP_STA: begin res.we = 1'b1; res.wd = a_old; end
            OP_STX: begin res.we = 1'b1; res.wd = reg_x; end
            OP_STY: begin res.we = 1'b1; res.wd = reg_y; end
            OP_TAX: begin reg_x = a_old;  set_nz(reg_x); end
            OP_TAY: begin reg_y = a_old;  set_nz(reg_y); end
            OP_TSX: begin reg_x = reg_sp; set_nz(reg_x); end
            OP_TXA: begin reg_a = reg_x;  set_nz(reg_a); end
            OP_TXS: reg_sp = reg_x;
            OP_TYA: begin reg_a = reg_y;  set_nz(reg_a); end
            OP_CMP: compare_reg(a_old, m);
            OP_CPX: compare_reg(reg_x, m);
            OP_CPY: compare_reg(reg_y, m);
            OP_NOP: ;
            default: res.ni = 1'b1;
        endcase
        res.a      = reg_a;
        res.x      = reg_x;
        res.y      = reg_y;
        res.sp     = reg_sp;
        res.status = status_byte(flags);
    endtask

    task automatic check_result(input t_exec_result got, input t_exec_result want);
        if (got.we != want.we)
            report_mismatch($sformatf("write_enable %0h, expected %0h", got.we, want.we));
        if (got.wd != want.wd)
            report_mismatch($sformatf("write_data %02h, expected %02h", got.wd, want.wd));
        if (got.sa != want.sa)
            report_mismatch($sformatf("stack_access %0d, expected %0d", got.sa, want.sa));
        if (got.saddr != want.saddr)
            report_mismatch($sformatf("stack_address %03h, expected %03h",
                                      got.saddr, want.saddr));
        if (got.a != want.a)
            report_mismatch($sformatf("acc_out %02h, expected %02h", got.a, want.a));
        if (got.x != want.x)
            report_mismatch($sformatf("x_out %02h, expected %02h", got.x, want.x));
        if (got.y != want.y)
            report_mismatch($sformatf("y_out %02h, expected %02h", got.y, want.y));
        if (got.sp != want.sp)
            report_mismatch($sformatf("sp_out %02h, expected %02h", got.sp, want.sp));
        if (got.status != want.status)
            report_mismatch($sformatf("status_out %02h, expected %02h",
                                      got.status, want.status));
        if (got.ni != want.ni)
            report_mismatch($sformatf("not_implemented %0h, expected %0h", got.ni, want.ni));
    endtask

    // Predict on accepted items, compare on accepted results
    always @(posedge i_clk) begin
        t_exec_result want;
        t_exec_result got;
        if (!i_rst_n) begin
            reg_a  = 8'h00;
            reg_x  = 8'h00;
            reg_y  = 8'h00;
            reg_sp = 8'hFF;
            flags  = '0;
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                execute_op(i_kind, i_operand, i_acc_mode, want);
                expected_results.push_back(want);
                items_seen++;
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_write_enable, i_write_data, i_stack_access, i_stack_address,
                        i_acc_out, i_x_out, i_y_out, i_sp_out, i_status_out,
                        i_not_implemented};
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    check_result(got, expected_results.pop_front());
                end
            end
        end
        o_outstanding <= expected_results.size();
    end

endmodule

FILE: bench/cpu6502_execute_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu6502_execute_unit_test
// Drives the execute unit with directed corner cases and random operation
// mixes under varying idle and stall pressure; a side checker does the
// prediction and comparison, this top only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module cpu6502_execute_unit_test;
    import cpu65_pkg::*;

    localparam logic [5:0] OP_FIRST_UNKNOWN = 6'd43;
    localparam logic [5:0] OP_LAST_CODE     = 6'd63;
    localparam int         WATCHDOG_LIMIT   = 4000;
    localparam int         LONG_HOLD        = 64;
    localparam int         PHASE_ITEMS      = 250;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [5:0] i_kind      = '0;
    logic [7:0] i_operand   = '0;
    logic       i_acc_mode  = 1'b0;
    logic       i_out_stall = 1'b0;

    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_write_enable;
    logic [7:0] o_write_data;
    logic [1:0] o_stack_access;
    logic [8:0] o_stack_address;
    logic [7:0] o_acc_out;
    logic [7:0] o_x_out;
    logic [7:0] o_y_out;
    logic [7:0] o_sp_out;
    logic [7:0] o_status_out;
    logic       o_not_implemented;

    int fail_count;
    int outstanding;
    int items_seen;
    int results_seen;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;
    int quiet_cycles  = 0;

    always #6 i_clk = ~i_clk;

    cpu6502_execute_unit dut (.*);

    cpu6502_execute_unit_checker result_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_operand         (i_operand),
        .i_acc_mode        (i_acc_mode),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_write_enable    (o_write_enable),
        .i_write_data      (o_write_data),
        .i_stack_access    (o_stack_access),
        .i_stack_address   (o_stack_address),
        .i_acc_out         (o_acc_out),
        .i_x_out           (o_x_out),
        .i_y_out           (o_y_out),
        .i_sp_out          (o_sp_out),
        .i_status_out      (o_status_out),
        .i_not_implemented (o_not_implemented),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding),
        .o_items_seen      (items_seen),
        .o_results_seen    (results_seen)
    );

    // Result side: random stalls, or a long hold-off when asked for
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one item, with random idle cycles ahead of it, until accepted
    task automatic send_item(input logic [5:0] op, input logic [7:0] m, input logic accm);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= op;
        i_operand  <= m;
        i_acc_mode <= accm;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Mostly official operations, operands biased toward the edges
    task automatic send_random(input int count);
        logic [5:0] op;
        logic [7:0] m;
        repeat (count) begin
            if ($urandom_range(99) < 92) begin
                op = 6'($urandom_range(OP_NOP));
            end else begin
                op = 6'($urandom_range(OP_LAST_CODE, OP_FIRST_UNKNOWN));
            end
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(4))
                    0:       m = 8'h00;
                    1:       m = 8'h01;
                    2:       m = 8'h7F;
                    3:       m = 8'h80;
                    default: m = 8'hFF;
                endcase
            end else begin
                m = 8'($urandom_range(255));
            end
            send_item(op, m, 1'($urandom_range(1)));
        end
    endtask

    // Sender stops until every outstanding result has been taken
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: stack wrap both ways, flag loads, binary math with D set,
        // shifts on A and memory, counter wrap, compares, unknown codes
        send_item(OP_LDX, 8'h00, 1'b0);
        send_item(OP_TXS, 8'h00, 1'b0);
        send_item(OP_PHA, 8'h00, 1'b0);
        send_item(OP_PLA, 8'h80, 1'b0);
        send_item(OP_PLP, 8'hFF, 1'b0);
        send_item(OP_PHP, 8'h00, 1'b0);
        send_item(OP_PLP, 8'h00, 1'b0);
        send_item(OP_SED, 8'h00, 1'b0);
        send_item(OP_LDA, 8'h7F, 1'b0);
        send_item(OP_ADC, 8'h01, 1'b0);
        send_item(OP_SEC, 8'h00, 1'b0);
        send_item(OP_SBC, 8'hFF, 1'b0);
        send_item(OP_ASL, 8'h00, 1'b1);
        send_item(OP_ROR, 8'h01, 1'b0);
        send_item(OP_ROL, 8'hFF, 1'b1);
        send_item(OP_LSR, 8'hFF, 1'b0);
        send_item(OP_DEC, 8'h00, 1'b0);
        send_item(OP_INC, 8'hFF, 1'b0);
        send_item(OP_CMP, 8'h80, 1'b0);
        send_item(OP_CPX, 8'hFF, 1'b0);
        send_item(OP_BIT, 8'hC0, 1'b0);
        send_item(OP_LDY, 8'hFF, 1'b1);
        send_item(OP_STY, 8'h00, 1'b0);
        send_item(OP_NOP, 8'hFF, 1'b1);
        send_item(OP_FIRST_UNKNOWN, 8'hFF, 1'b1);
        send_item(OP_LAST_CODE, 8'h00, 1'b0);
        wait_drained();

        // Full rate, with a long output hold in the middle
        send_idle_pct = 0;
        stall_pct     = 0;
        send_random(PHASE_ITEMS / 2);
        hold_req = 1'b1;
        send_random(PHASE_ITEMS / 2);
        wait_drained();

        // Sparse sender
        send_idle_pct = 79;
        stall_pct     = 0;
        send_random(PHASE_ITEMS);
        wait_drained();

        // Heavily stalled receiver
        send_idle_pct = 0;
        stall_pct     = 79;
        send_random(PHASE_ITEMS);
        wait_drained();

        // Both sides throttled
        send_idle_pct = 34;
        stall_pct     = 34;
        send_random(PHASE_ITEMS);
        wait_drained();

        stall_pct = 0;
        repeat (8) @(posedge i_clk);

        $display("Ran %0d items: directed corners, then random mixes of all 43 operations",
                 items_seen);
        $display("and unknown codes; %0d results checked under idle, stall and hold-off",
                 results_seen);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
